### sv/sorted_unique_cursor_set_core_assert.svh
// Assertion macros shared by the sorted unique cursor set RTL.
`ifndef SORTED_UNIQUE_CURSOR_SET_CORE_ASSERT_SVH
`define SORTED_UNIQUE_CURSOR_SET_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SUCS_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SUCS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sucs_pkg.sv
// Types and constants for the sorted unique cursor set.
`timescale 1ns / 1ps

package sucs_pkg;

	localparam int OFFSET_W = 24;

	typedef struct packed {
		logic [OFFSET_W-1:0] cursor_offset;
		logic                batch_end;
	} sucs_in_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] sorted_offset;
		logic                final_result;
		logic                capacity_exceeded;
	} sucs_out_t;

	typedef struct packed {
		logic insert;
		logic shift_out;
	} sucs_ctrl_t;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'b01,
		ST_EMIT   = 2'b10
	} sucs_state_t;

endpackage

### sv/sucs_cell.sv
// One compare-and-shift cell of the sorted store.
`timescale 1ns / 1ps

module sucs_cell import sucs_pkg::*; #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  sucs_ctrl_t   ctrl,
	input  logic [W-1:0] new_value,
	input  logic [W-1:0] prev_value,
	input  logic         prev_valid,
	input  logic         prev_lt,
	input  logic [W-1:0] next_value,
	input  logic         next_valid,
	output logic [W-1:0] value,
	output logic         valid,
	output logic         lt,
	output logic         eq
);

	logic [W-1:0] value_q;
	logic         valid_q;

	assign lt    = valid_q && (value_q < new_value);
	assign eq    = valid_q && (value_q == new_value);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!lt) begin
				value_q <= prev_lt ? new_value : prev_value;
			end
		end else if (ctrl.shift_out) begin
			value_q <= next_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (!lt) begin
				valid_q <= prev_lt ? 1'b1 : prev_valid;
			end
		end else if (ctrl.shift_out) begin
			valid_q <= next_valid;
		end
	end

endmodule

### sv/sorted_unique_cursor_set_core.sv
// Sorted unique cursor set: a batch of offsets in, distinct offsets out in ascending order.
// Offsets are held in a row of MAX_ENTRIES compare-and-shift cells kept in ascending order.
// While a batch is collected one offset is accepted every cycle; each is compared against
// all cells at once, dropped if already held, otherwise inserted with the larger entries
// moving one cell up. A distinct offset arriving with the store full is dropped and flagged
// on the batch's final result. The transaction carrying batch_end starts emission: the row
// shifts toward cell 0 and one result leaves per cycle while the output is not stalled;
// no input is accepted until the batch has drained. The store is empty again after the
// final result. Only the low OFFSET_BITS bits of an offset are kept.
`timescale 1ns / 1ps

`include "sorted_unique_cursor_set_core_assert.svh"

module sorted_unique_cursor_set_core import sucs_pkg::*; #(
	parameter int MAX_ENTRIES = 32,
	parameter int OFFSET_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  sucs_in_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output sucs_out_t result
);

	sucs_state_t              state_q;
	logic                     ovf_q;
	logic                     out_valid_q;
	sucs_out_t                out_q;

	logic [OFFSET_BITS-1:0]   new_value;
	logic [OFFSET_BITS-1:0]   cell_value [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]   cell_valid;
	logic [MAX_ENTRIES-1:0]   cell_lt;
	logic [MAX_ENTRIES-1:0]   cell_eq;
	sucs_ctrl_t               ctrl;

	logic in_fire;
	logic dup;
	logic full;
	logic load;
	logic last_entry;

	assign new_value  = OFFSET_BITS'(item.cursor_offset);
	assign item_ready = (state_q == ST_ACCEPT);
	assign in_fire    = item_valid && item_ready;
	assign dup        = |cell_eq;
	assign full       = cell_valid[MAX_ENTRIES-1];
	assign load       = (state_q == ST_EMIT) && (!out_valid_q || result_ready);
	assign last_entry = !cell_valid[1];

	assign ctrl.insert    = in_fire && !dup && !full;
	assign ctrl.shift_out = load;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic [OFFSET_BITS-1:0] p_value;
		logic                   p_valid;
		logic                   p_lt;
		logic [OFFSET_BITS-1:0] n_value;
		logic                   n_valid;

		if (i == 0) begin : g_head
			assign p_value = '0;
			assign p_valid = 1'b0;
			assign p_lt    = 1'b1;
		end else begin : g_body
			assign p_value = cell_value[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_lt    = cell_lt[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign n_value = '0;
			assign n_valid = 1'b0;
		end else begin : g_mid
			assign n_value = cell_value[i+1];
			assign n_valid = cell_valid[i+1];
		end

		sucs_cell #(
			.W (OFFSET_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_value  (new_value),
			.prev_value (p_value),
			.prev_valid (p_valid),
			.prev_lt    (p_lt),
			.next_value (n_value),
			.next_valid (n_valid),
			.value      (cell_value[i]),
			.valid      (cell_valid[i]),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (in_fire && !dup && full) begin
						ovf_q <= 1'b1;
					end
					if (in_fire && item.batch_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load && last_entry) begin
						state_q <= ST_ACCEPT;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.sorted_offset     <= OFFSET_W'(cell_value[0]);
			out_q.final_result      <= last_entry;
			out_q.capacity_exceeded <= last_entry && ovf_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`SUCS_ASSERT_IMPL(a_emit_nonempty, clk, arst_n, state_q == ST_EMIT, cell_valid[0],
		"emission started with an empty store")
	`SUCS_ASSERT_NEXT(a_final_clears, clk, arst_n, load && last_entry,
		state_q == ST_ACCEPT && !cell_valid[0] && !ovf_q,
		"store not empty after final transaction")
	`SUCS_ASSERT_IMPL(a_head_sorted, clk, arst_n, cell_valid[1],
		cell_valid[0] && (cell_value[0] < cell_value[1]),
		"head cells out of order")
	`SUCS_ASSERT_IMPL(a_no_insert_emit, clk, arst_n, state_q == ST_EMIT, !ctrl.insert,
		"insert during emission")

endmodule

### tb/sorted_unique_cursor_set_checker.sv
// Scoreboard for the sorted unique cursor set: predicts each batch's sorted output and compares.
`timescale 1ns / 1ps

module sorted_unique_cursor_set_checker import sucs_pkg::*; #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_ready,
	input  sucs_in_t  item,
	input  logic      result_valid,
	input  logic      result_ready,
	input  sucs_out_t result,
	output int        mismatches,
	output int        due_count,
	output int        batches_done,
	output int        results_done,
	output int        overflow_batches
);

	logic [OFFSET_W-1:0] held_offsets[$];
	bit                  dropped_for_room = 1'b0;
	sucs_out_t           sorted_due[$];
	int                  mismatch_count = 0;
	int                  due_now = 0;
	int                  batch_count = 0;
	int                  result_count = 0;
	int                  overflow_count = 0;

	assign mismatches       = mismatch_count;
	assign due_count        = due_now;
	assign batches_done     = batch_count;
	assign results_done     = result_count;
	assign overflow_batches = overflow_count;

	task automatic absorb_offset(input sucs_in_t t);
		int        pos;
		sucs_out_t r;
		pos = 0;
		while (pos < held_offsets.size() && held_offsets[pos] < t.cursor_offset)
			pos++;
		if (!(pos < held_offsets.size() && held_offsets[pos] == t.cursor_offset)) begin
			if (held_offsets.size() >= MAX_ENTRIES)
				dropped_for_room = 1'b1;
			else
				held_offsets.insert(pos, t.cursor_offset);
		end
		if (t.batch_end) begin
			foreach (held_offsets[k]) begin
				r.sorted_offset     = held_offsets[k];
				r.final_result      = (k == held_offsets.size() - 1);
				r.capacity_exceeded = r.final_result && dropped_for_room;
				sorted_due.push_back(r);
			end
			batch_count++;
			if (dropped_for_room)
				overflow_count++;
			held_offsets.delete();
			dropped_for_room = 1'b0;
		end
	endtask

	task automatic check_result(input sucs_out_t got);
		sucs_out_t want;
		if (sorted_due.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected result: expected none, actual %h", $time, got);
		end else begin
			want = sorted_due.pop_front();
			result_count++;
			if (got.sorted_offset !== want.sorted_offset) begin
				mismatch_count++;
				$display("%0t: sorted_offset: expected %h, actual %h", $time,
					want.sorted_offset, got.sorted_offset);
			end
			if (got.final_result !== want.final_result) begin
				mismatch_count++;
				$display("%0t: final_result: expected %b, actual %b", $time,
					want.final_result, got.final_result);
			end
			if (got.capacity_exceeded !== want.capacity_exceeded) begin
				mismatch_count++;
				$display("%0t: capacity_exceeded: expected %b, actual %b", $time,
					want.capacity_exceeded, got.capacity_exceeded);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				absorb_offset(item);
			if (result_valid && result_ready)
				check_result(result);
			due_now <= sorted_due.size();
		end
	end

endmodule

### tb/sorted_unique_cursor_set_core_tb.sv
// Top-level testbench for the sorted unique cursor set: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module sorted_unique_cursor_set_core_tb;
	import sucs_pkg::*;

	typedef enum int {
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} idle_phase_t;

	localparam int MAX_ENTRIES      = 32;
	localparam int RANDOM_PER_PHASE = 113;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	sucs_in_t  item         = '0;
	logic      result_ready = 1'b0;
	logic      item_ready;
	logic      result_valid;
	sucs_out_t result;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int offsets_sent   = 0;
	int mismatches;
	int due_count;
	int batches_done;
	int results_done;
	int overflow_batches;

	logic [OFFSET_W-1:0] batch_offsets[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	sorted_unique_cursor_set_core #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.OFFSET_BITS(OFFSET_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	sorted_unique_cursor_set_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.mismatches(mismatches),
		.due_count(due_count),
		.batches_done(batches_done),
		.results_done(results_done),
		.overflow_batches(overflow_batches)
	);

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_offset(input logic [OFFSET_W-1:0] v, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{cursor_offset: v, batch_end: last};
		do
			@(posedge clk);
		while (!item_ready);
		offsets_sent++;
	endtask

	task automatic send_batch();
		foreach (batch_offsets[k])
			send_offset(batch_offsets[k], k == batch_offsets.size() - 1);
		batch_offsets.delete();
	endtask

	// large batches overrun the store; narrow-range batches are full of duplicates
	task automatic build_random_batch(input bit force_large);
		int                  kind;
		int                  len;
		logic [OFFSET_W-1:0] v;
		logic [OFFSET_W-1:0] base;
		kind = force_large ? 0 : $urandom_range(11);
		base = OFFSET_W'($urandom);
		if (kind == 0)
			len = $urandom_range(40, 33);
		else if (kind <= 2)
			len = $urandom_range(10, 1);
		else
			len = $urandom_range(8, 1);
		for (int k = 0; k < len; k++) begin
			if (kind == 0)
				v = OFFSET_W'($urandom);
			else if (kind <= 2)
				v = base + OFFSET_W'($urandom_range(7));
			else begin
				case ($urandom_range(7))
					0: v = (batch_offsets.size() != 0) ?
						batch_offsets[$urandom_range(batch_offsets.size() - 1)] : '0;
					1: v = $urandom_range(1) ? '1 : '0;
					default: v = OFFSET_W'($urandom);
				endcase
			end
			batch_offsets.push_back(v);
		end
		if (kind == 0 && $urandom_range(1))
			batch_offsets[len-1] = batch_offsets[$urandom_range(len - 2)];
	endtask

	initial begin
		idle_phase_t ph;
		int          phase_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		batch_offsets = '{24'h000000};
		send_batch();
		batch_offsets = '{24'hffffff};
		send_batch();
		batch_offsets = '{24'h000005, 24'h000005};
		send_batch();
		batch_offsets = '{24'hffffff, 24'h000000, 24'h800000, 24'h000000,
			24'h555555, 24'haaaaaa, 24'hffffff};
		send_batch();
		batch_offsets = '{24'h000040, 24'h000030, 24'h000020, 24'h000010};
		send_batch();
		batch_offsets = '{24'h000007, 24'h000007, 24'h000007};
		send_batch();

		for (int p = 0; p < 4; p++) begin
			ph = idle_phase_t'(p);
			case (ph)
				PH_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				PH_SEND_IDLE:  begin send_idle_pct = 73; recv_stall_pct = 0;  end
				PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				PH_BOTH:       begin send_idle_pct = 12; recv_stall_pct = 12; end
				default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase
			phase_start = offsets_sent;
			build_random_batch(1'b1);
			send_batch();
			while (offsets_sent - phase_start < RANDOM_PER_PHASE) begin
				build_random_batch(1'b0);
				send_batch();
			end
		end
		item_valid <= 1'b0;

		do
			@(posedge clk);
		while (due_count != 0);
		repeat (20) @(posedge clk);

		$display("Ran %0d offsets in %0d batches; %0d sorted results checked,",
			offsets_sent, batches_done, results_done);
		$display("%0d batches overflowed the store.", overflow_batches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
